FILE: src/mips_cp0_exception_unit_assert.svh
// Assertion helpers shared by the CP0 exception unit sources.
`ifndef MIPS_CP0_EXCEPTION_UNIT_ASSERT_SVH
`define MIPS_CP0_EXCEPTION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCP0_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcp0 assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MCP0_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcp0 assertion failed");

`endif

FILE: src/mcp0_pkg.sv
`default_nettype none

package mcp0_pkg;

    // APB register map
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_IDX_INTR_DIS = 1'b0;  // word index in paddr[2]

    // Status / Cause bit positions
    localparam int unsigned ST_IE  = 0;
    localparam int unsigned ST_EXL = 1;
    localparam int unsigned ST_ERL = 2;
    localparam int unsigned ST_BEV = 22;
    localparam int unsigned IM_LO  = 8;
    localparam int unsigned IM_HI  = 15;
    localparam int unsigned EC_LO  = 2;
    localparam int unsigned EC_HI  = 6;
    localparam int unsigned CA_BD  = 31;
    localparam int unsigned TIMER_LINE = 7;

    localparam logic [31:0] STATUS_RESET = 32'h0040_0000;
    localparam logic [4:0]  INT_CAUSE_CODE = 5'd0;

    localparam logic [63:0] VEC_OFS  = 64'h0000_0000_0000_0180;
    localparam logic [63:0] VEC_BOOT = 64'hffff_ffff_bfc0_0200;
    localparam logic [63:0] VEC_NORM = 64'hffff_ffff_8000_0000;

    typedef enum logic [2:0] {
        OP_EXC          = 3'd0,
        OP_IRQ_CHECK    = 3'd1,
        OP_ERET         = 3'd2,
        OP_SET_LINES    = 3'd3,
        OP_TIMER_IRQ    = 3'd4,
        OP_WR_STATUS    = 3'd5,
        OP_WR_EPC       = 3'd6,
        OP_WR_ERROR_EPC = 3'd7
    } op_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [4:0]  exc_cause;
        logic        in_delay_slot;
        logic [63:0] current_pc;
        logic [7:0]  irq_lines;
        logic [63:0] write_value;
    } evt_t;

    typedef struct packed {
        logic        redirect;
        logic [63:0] next_pc;
        logic        int_pending;
        logic [31:0] status;
        logic [31:0] cause;
        logic [63:0] epc;
    } res_t;

    typedef struct packed {
        logic [31:0] status;
        logic [31:0] cause;
        logic [63:0] epc;
        logic [63:0] error_epc;
        logic [7:0]  lines;
        logic        flag;
    } cp0_state_t;

    // Load Cause.IP from the latched lines and recompute the pending flag.
    function automatic cp0_state_t flag_update(cp0_state_t s);
        cp0_state_t r;
        r = s;
        r.cause[IM_HI:IM_LO] = s.lines;
        r.flag = s.status[ST_IE] && !s.status[ST_EXL] && !s.status[ST_ERL] &&
                 ((s.lines & s.status[IM_HI:IM_LO]) != 8'h00);
        return r;
    endfunction

    // EPC/BD are only captured when not already at exception level.
    function automatic cp0_state_t take_exc(cp0_state_t s, logic [4:0] code,
                                            logic bd, logic [63:0] pc);
        cp0_state_t r;
        r = s;
        r.cause = '0;
        r.cause[IM_HI:IM_LO] = s.cause[IM_HI:IM_LO];
        if (!s.status[ST_EXL])
        begin
            r.epc = pc;
            r.cause[CA_BD] = bd;
        end
        else
        begin
            r.cause[CA_BD] = s.cause[CA_BD];
        end
        r.cause[EC_HI:EC_LO] = code;
        r.status[ST_EXL] = 1'b1;
        r.flag = 1'b0;
        return r;
    endfunction

    function automatic logic [63:0] exc_vector(logic [31:0] status);
        return status[ST_BEV] ? (VEC_BOOT + VEC_OFS) : (VEC_NORM + VEC_OFS);
    endfunction

endpackage

`default_nettype wire

FILE: src/mcp0_event_if.sv
`default_nettype none

interface mcp0_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [4:0]  exc_cause;
    logic        in_delay_slot;
    logic [63:0] current_pc;
    logic [7:0]  irq_lines;
    logic [63:0] write_value;

    modport source (
        output valid, opcode, exc_cause, in_delay_slot, current_pc, irq_lines, write_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, exc_cause, in_delay_slot, current_pc, irq_lines, write_value,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/mcp0_result_if.sv
`default_nettype none

interface mcp0_result_if;
    logic        valid;
    logic        ready;
    logic        redirect;
    logic [63:0] next_pc;
    logic        int_pending;
    logic [31:0] status_out;
    logic [31:0] cause_out;
    logic [63:0] epc_out;

    modport source (
        output valid, redirect, next_pc, int_pending, status_out, cause_out, epc_out,
        input  ready
    );
    modport sink (
        input  valid, redirect, next_pc, int_pending, status_out, cause_out, epc_out,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/mips_cp0_exception_unit.sv
// An accepted event is held in the input register; its result is registered in the output register when it advances.
// Throughput: one event per cycle while the result channel is not stalled; each event updates CP0 state as it advances.
// The input register refills while a finished result waits in the output register.
// Reset (rst_n, async, active low): Status=BEV, Cause/EPC/ErrorEPC/lines/flag cleared,
// interrupts_disabled cleared, both register stages emptied.
`default_nettype none

`include "mips_cp0_exception_unit_assert.svh"

module mips_cp0_exception_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // APB configuration port
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mcp0_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [mcp0_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [mcp0_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    // event and result channels
    mcp0_event_if.sink                               evt,
    mcp0_result_if.source                            res
);

    logic             intr_dis;

    // input register stage
    logic             evt_valid_reg;
    logic             evt_valid_next;
    mcp0_pkg::evt_t   evt_reg;
    logic             evt_take;

    // output register stage
    logic             res_valid_reg;
    logic             res_valid_next;
    mcp0_pkg::res_t   res_reg;
    mcp0_pkg::res_t   core_res;

    // advance: the event in the input register is applied to CP0 state and
    // its result lands in the output register in the same edge.
    logic             advance;

    mcp0_apb u_apb (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .intr_dis (intr_dis)
    );

    mcp0_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .ev       (evt_reg),
        .intr_dis (intr_dis),
        .res      (core_res)
    );

    assign advance   = evt_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !evt_valid_reg || advance;
    assign evt_take  = evt.valid && evt.ready;

    always_comb
    begin
        evt_valid_next = evt_valid_reg;
        if (evt_take)
        begin
            evt_valid_next = 1'b1;
        end
        else if (advance)
        begin
            evt_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            evt_valid_reg <= evt_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            evt_reg.opcode        <= evt.opcode;
            evt_reg.exc_cause     <= evt.exc_cause;
            evt_reg.in_delay_slot <= evt.in_delay_slot;
            evt_reg.current_pc    <= evt.current_pc;
            evt_reg.irq_lines     <= evt.irq_lines;
            evt_reg.write_value   <= evt.write_value;
        end
        if (advance)
        begin
            res_reg <= core_res;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.redirect    = res_reg.redirect;
    assign res.next_pc     = res_reg.next_pc;
    assign res.int_pending = res_reg.int_pending;
    assign res.status_out  = res_reg.status;
    assign res.cause_out   = res_reg.cause;
    assign res.epc_out     = res_reg.epc;

    `MCP0_ASSERT_NXT(a_advance_fills_out, clk, rst_n,
        advance,
        res_valid_reg)
    `MCP0_ASSERT_NXT(a_stalled_result_held, clk, rst_n,
        res_valid_reg && !res.ready,
        res_valid_reg && $stable(res_reg))
    `MCP0_ASSERT_IMP(a_empty_input_ready, clk, rst_n,
        !evt_valid_reg,
        evt.ready)

endmodule

`default_nettype wire

FILE: src/mcp0_apb.sv
`default_nettype none

module mcp0_apb (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mcp0_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [mcp0_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [mcp0_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready,
    output logic                                     intr_dis
);

    logic intr_dis_reg;
    logic intr_dis_next;
    logic wr_en;
    logic sel_intr_dis;

    assign pready       = 1'b1;
    assign sel_intr_dis = (paddr[mcp0_pkg::APB_ADDR_W-1] == mcp0_pkg::REG_IDX_INTR_DIS);
    assign wr_en        = psel && penable && pwrite && pready;

    always_comb
    begin
        intr_dis_next = intr_dis_reg;
        if (wr_en && sel_intr_dis)
        begin
            intr_dis_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            intr_dis_reg <= 1'b0;
        end
        else
        begin
            intr_dis_reg <= intr_dis_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (sel_intr_dis)
        begin
            prdata[0] = intr_dis_reg;
        end
    end

    assign intr_dis = intr_dis_reg;

endmodule

`default_nettype wire

FILE: src/mcp0_core.sv
`default_nettype none

`include "mips_cp0_exception_unit_assert.svh"

module mcp0_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire mcp0_pkg::evt_t     ev,
    input  wire logic               intr_dis,
    output mcp0_pkg::res_t          res
);

    mcp0_pkg::cp0_state_t state_reg;
    mcp0_pkg::cp0_state_t state_next;
    mcp0_pkg::cp0_state_t upd;
    mcp0_pkg::cp0_state_t tmp;
    logic                 redirect;
    logic [63:0]          npc;

    always_comb
    begin
        upd        = mcp0_pkg::flag_update(state_reg);
        tmp        = state_reg;
        state_next = state_reg;
        redirect   = 1'b0;
        npc        = '0;
        case (mcp0_pkg::op_t'(ev.opcode))
            mcp0_pkg::OP_EXC:
            begin
                state_next = mcp0_pkg::take_exc(state_reg, ev.exc_cause,
                                                ev.in_delay_slot, ev.current_pc);
                redirect   = 1'b1;
                npc        = mcp0_pkg::exc_vector(state_reg.status);
            end
            mcp0_pkg::OP_IRQ_CHECK:
            begin
                if (intr_dis)
                begin
                    state_next.flag = 1'b0;
                end
                else if (upd.flag)
                begin
                    state_next = mcp0_pkg::take_exc(upd, mcp0_pkg::INT_CAUSE_CODE,
                                                    1'b0, ev.current_pc);
                    redirect   = 1'b1;
                    npc        = mcp0_pkg::exc_vector(upd.status);
                end
                else
                begin
                    state_next = upd;
                end
            end
            mcp0_pkg::OP_ERET:
            begin
                // ERL takes priority over EXL
                if (state_reg.status[mcp0_pkg::ST_ERL])
                begin
                    tmp.status[mcp0_pkg::ST_ERL] = 1'b0;
                    npc = state_reg.error_epc;
                end
                else
                begin
                    tmp.status[mcp0_pkg::ST_EXL] = 1'b0;
                    npc = state_reg.epc;
                end
                redirect   = 1'b1;
                state_next = mcp0_pkg::flag_update(tmp);
            end
            mcp0_pkg::OP_SET_LINES:
            begin
                state_next.lines = ev.irq_lines;
            end
            mcp0_pkg::OP_TIMER_IRQ:
            begin
                tmp.lines[mcp0_pkg::TIMER_LINE] = 1'b1;
                state_next = mcp0_pkg::flag_update(tmp);
            end
            mcp0_pkg::OP_WR_STATUS:
            begin
                state_next.status = ev.write_value[31:0];
            end
            mcp0_pkg::OP_WR_EPC:
            begin
                state_next.epc = ev.write_value;
            end
            mcp0_pkg::OP_WR_ERROR_EPC:
            begin
                state_next.error_epc = ev.write_value;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.status    <= mcp0_pkg::STATUS_RESET;
            state_reg.cause     <= '0;
            state_reg.epc       <= '0;
            state_reg.error_epc <= '0;
            state_reg.lines     <= '0;
            state_reg.flag      <= 1'b0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    assign res.redirect    = redirect;
    assign res.next_pc     = npc;
    assign res.int_pending = state_next.flag;
    assign res.status      = state_next.status;
    assign res.cause       = state_next.cause;
    assign res.epc         = state_next.epc;

    `MCP0_ASSERT_NXT(a_exc_sets_exl, clk, rst_n,
        fire && (ev.opcode == mcp0_pkg::OP_EXC),
        state_reg.status[mcp0_pkg::ST_EXL] && !state_reg.flag)
    `MCP0_ASSERT_NXT(a_set_lines_quiet, clk, rst_n,
        fire && (ev.opcode == mcp0_pkg::OP_SET_LINES),
        (state_reg.cause == $past(state_reg.cause)) &&
        (state_reg.flag == $past(state_reg.flag)))
    `MCP0_ASSERT_NXT(a_idle_holds, clk, rst_n,
        !fire,
        $stable(state_reg))

endmodule

`default_nettype wire
